FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl files; the top level includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define BLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define BLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define BLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/blp_pkg.sv
// package: constants, codes and control types of the bounded positional list
`default_nettype none

package blp_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int HANDLE_W    = 32;
	localparam int BYTES_W     = 16;
	localparam int REQ_W       = 4;
	localparam int POS_W       = 6;
	localparam int STATUS_W    = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_FIRST  = 4'd0,
		REQ_INS_LAST   = 4'd1,
		REQ_INS_AT     = 4'd2,
		REQ_EXT_FIRST  = 4'd3,
		REQ_EXT_LAST   = 4'd4,
		REQ_EXT_AT     = 4'd5,
		REQ_PEEK_FIRST = 4'd6,
		REQ_PEEK_LAST  = 4'd7,
		REQ_PEEK_AT    = 4'd8,
		REQ_CLEAR      = 4'd9,
		REQ_RESIZE     = 4'd10
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_ZERO_SIZE = 3'd1,
		ST_NULL      = 3'd2,
		ST_FULL      = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_GET_RD,
		S_GET_WAIT,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic rd_k;
		logic rd_idx;
		logic wr_up;
		logic wr_down;
		logic put;
		logic grab;
		logic dec_cnt;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic ins_ok;
		logic get_ok;
		logic ext;
		logic shift_need;
		logic k_at_idx;
		logic move_need;
		logic k_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/blp_ctrl.sv
// controller state machine sequencing shifts, reads and result delivery
`default_nettype none

module blp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire blp_pkg::stat_t stat,
	output blp_pkg::cmd_t       cmd
);
	import blp_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.ins_ok) begin
					state_nx = stat.shift_need ? S_SHIFT_RD : S_PUT;
				end else if (stat.get_ok) begin
					state_nx = S_GET_RD;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_SHIFT_RD: begin
				cmd.rd_k = 1'b1;
				state_nx = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				cmd.wr_up = 1'b1;
				state_nx  = stat.k_at_idx ? S_PUT : S_SHIFT_RD;
			end
			S_PUT: begin
				cmd.put  = 1'b1;
				state_nx = S_DONE;
			end
			S_GET_RD: begin
				cmd.rd_idx = 1'b1;
				state_nx   = S_GET_WAIT;
			end
			S_GET_WAIT: begin
				cmd.grab = 1'b1;
				if (!stat.ext) begin
					state_nx = S_DONE;
				end else if (stat.move_need) begin
					state_nx = S_MOVE_RD;
				end else begin
					cmd.dec_cnt = 1'b1;
					state_nx    = S_DONE;
				end
			end
			S_MOVE_RD: begin
				cmd.rd_k = 1'b1;
				state_nx = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				cmd.wr_down = 1'b1;
				if (stat.k_last) begin
					cmd.dec_cnt = 1'b1;
					state_nx    = S_DONE;
				end else begin
					state_nx = S_MOVE_RD;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/blp_datapath.sv
// datapath: entry memory, count and capacity, request decode and result register
`default_nettype none

module blp_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire blp_pkg::cmd_t                  cmd,
	output blp_pkg::stat_t                      stat,
	input  wire logic [blp_pkg::REQ_W-1:0]      req_type,
	input  wire logic [blp_pkg::POS_W-1:0]      position,
	input  wire logic [blp_pkg::HANDLE_W-1:0]   payload_handle,
	input  wire logic [blp_pkg::BYTES_W-1:0]    payload_bytes,
	input  wire logic [blp_pkg::CNT_W-1:0]      new_capacity,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [blp_pkg::STATUS_W-1:0]        status,
	output logic [blp_pkg::HANDLE_W-1:0]        out_handle,
	output logic [blp_pkg::BYTES_W-1:0]         out_bytes,
	output logic [blp_pkg::CNT_W-1:0]           entry_count,
	output logic                                is_empty,
	output logic                                is_full,
	output logic [blp_pkg::CNT_W-1:0]           cur_capacity
);
	import blp_pkg::*;

	localparam int ENTRY_W = HANDLE_W + BYTES_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	// latched request
	logic [REQ_W-1:0]    req_q;
	logic [POS_W-1:0]    pos_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [CNT_W-1:0]    ncap_q;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    cap_q;
	logic [CNT_W-1:0]    k_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0] oh_q;
	logic [BYTES_W-1:0]  ob_q;

	logic [ENTRY_W-1:0]  mem [MAX_ENTRIES];
	logic [ENTRY_W-1:0]  rdata_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [BYTES_W-1:0]  out_bytes_q;
	logic [CNT_W-1:0]    out_count_q;
	logic                out_empty_q;
	logic                out_full_q;
	logic [CNT_W-1:0]    out_cap_q;

	// decode
	logic                is_ins;
	logic                is_get;
	logic                is_ext;
	logic                is_first;
	logic                is_last;
	logic [STATUS_W-1:0] dec_status;
	logic [CNT_W-1:0]    dec_idx;
	logic [CNT_W-1:0]    pos_ext;
	logic [CNT_W-1:0]    ncap_sat;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0]  wr_data;

	always_comb begin
		is_ins   = req_q inside {REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AT};
		is_get   = req_q inside {[REQ_EXT_FIRST:REQ_PEEK_AT]};
		is_ext   = req_q inside {REQ_EXT_FIRST, REQ_EXT_LAST, REQ_EXT_AT};
		is_first = req_q inside {REQ_INS_FIRST, REQ_EXT_FIRST, REQ_PEEK_FIRST};
		is_last  = req_q inside {REQ_INS_LAST, REQ_EXT_LAST, REQ_PEEK_LAST};
		pos_ext  = CNT_W'(pos_q);
		ncap_sat = (ncap_q > MAX_CNT) ? MAX_CNT : ncap_q;
		dec_status = ST_OK;
		dec_idx    = '0;
		if (is_ins) begin
			if (is_first) begin
				dec_idx = '0;
			end else if (is_last) begin
				dec_idx = count_q;
			end else begin
				dec_idx = (pos_ext >= count_q) ? count_q : pos_ext;
			end
			if (handle_q == '0) begin
				dec_status = ST_NULL;
			end else if (bytes_q == '0) begin
				dec_status = ST_ZERO_SIZE;
			end else if (count_q >= cap_q) begin
				dec_status = ST_FULL;
			end
		end else if (is_get) begin
			if (is_first) begin
				dec_idx = '0;
			end else if (is_last) begin
				dec_idx = count_q - 1'b1;
			end else begin
				dec_idx = pos_ext;
			end
			if (count_q == '0 || dec_idx >= count_q) begin
				dec_status = ST_RANGE;
			end
		end else if (req_q == REQ_RESIZE) begin
			if (ncap_q == '0) begin
				dec_status = ST_ZERO_SIZE;
			end
		end
	end

	always_comb begin
		stat            = '0;
		stat.ins_ok     = is_ins && (dec_status == ST_OK);
		stat.get_ok     = is_get && (dec_status == ST_OK);
		stat.ext        = is_ext;
		stat.shift_need = dec_idx < count_q;
		stat.k_at_idx   = k_q[ADDR_W-1:0] == idx_q;
		stat.move_need  = (CNT_W'(idx_q) + 1'b1) < count_q;
		stat.k_last     = k_q == (count_q - 1'b1);
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// memory port selection
	always_comb begin
		rd_en   = cmd.rd_k || cmd.rd_idx;
		rd_addr = cmd.rd_idx ? idx_q : k_q[ADDR_W-1:0];
		wr_en   = cmd.wr_up || cmd.wr_down || cmd.put;
		wr_data = cmd.put ? {handle_q, bytes_q} : rdata_q;
		if (cmd.put) begin
			wr_addr = idx_q;
		end else if (cmd.wr_up) begin
			wr_addr = k_q[ADDR_W-1:0] + 1'b1;
		end else begin
			wr_addr = k_q[ADDR_W-1:0] - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			pos_q    <= position;
			handle_q <= payload_handle;
			bytes_q  <= payload_bytes;
			ncap_q   <= new_capacity;
		end
		if (cmd.decode) begin
			status_q <= dec_status;
			idx_q    <= dec_idx[ADDR_W-1:0];
			oh_q     <= '0;
			ob_q     <= '0;
			k_q      <= count_q - 1'b1;
		end
		if (cmd.wr_up) begin
			k_q <= k_q - 1'b1;
		end
		if (cmd.wr_down) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.grab) begin
			oh_q <= rdata_q[ENTRY_W-1:BYTES_W];
			ob_q <= rdata_q[BYTES_W-1:0];
			k_q  <= CNT_W'(idx_q) + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= MAX_CNT;
		end else begin
			if (cmd.decode && req_q == REQ_CLEAR) begin
				count_q <= '0;
			end
			if (cmd.decode && req_q == REQ_RESIZE && ncap_q != '0) begin
				cap_q <= ncap_sat;
				if (count_q > ncap_sat) begin
					count_q <= ncap_sat;
				end
			end
			if (cmd.put) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.dec_cnt) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= status_q;
			out_handle_q <= oh_q;
			out_bytes_q  <= ob_q;
			out_count_q  <= count_q;
			out_empty_q  <= count_q == '0;
			out_full_q   <= count_q == cap_q;
			out_cap_q    <= cap_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign out_handle   = out_handle_q;
	assign out_bytes    = out_bytes_q;
	assign entry_count  = out_count_q;
	assign is_empty     = out_empty_q;
	assign is_full      = out_full_q;
	assign cur_capacity = out_cap_q;

endmodule

`default_nettype wire

FILE: rtl/core/bounded_positional_list.sv
// top level of the bounded positional list
//
//   channel   direction   handshake            payload
//   request   in          in_valid / in_stall  req_type position payload_handle
//                                              payload_bytes new_capacity
//   result    out         out_valid/out_stall  status out_handle out_bytes entry_count
//                                              is_empty is_full cur_capacity
//
// one transaction at a time; the work per request is set by the entry memory, which
// the controller reads and writes in separate states: a positional insert or extract
// moves each entry behind the position with one read and one write
// clear, resize and rejected requests move no entries; reset empties the list
// in_stall is high while a request is in work; a stalled result holds and a new
// request can be taken while it waits
`default_nettype none
`include "assert_macros.svh"

module bounded_positional_list (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [blp_pkg::REQ_W-1:0]      req_type,
	input  wire logic [blp_pkg::POS_W-1:0]      position,
	input  wire logic [blp_pkg::HANDLE_W-1:0]   payload_handle,
	input  wire logic [blp_pkg::BYTES_W-1:0]    payload_bytes,
	input  wire logic [blp_pkg::CNT_W-1:0]      new_capacity,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [blp_pkg::STATUS_W-1:0]        status,
	output logic [blp_pkg::HANDLE_W-1:0]        out_handle,
	output logic [blp_pkg::BYTES_W-1:0]         out_bytes,
	output logic [blp_pkg::CNT_W-1:0]           entry_count,
	output logic                                is_empty,
	output logic                                is_full,
	output logic [blp_pkg::CNT_W-1:0]           cur_capacity
);
	import blp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	blp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	blp_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req_type),
		.position       (position),
		.payload_handle (payload_handle),
		.payload_bytes  (payload_bytes),
		.new_capacity   (new_capacity),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.out_handle     (out_handle),
		.out_bytes      (out_bytes),
		.entry_count    (entry_count),
		.is_empty       (is_empty),
		.is_full        (is_full),
		.cur_capacity   (cur_capacity)
	);

	// an accepted request keeps the input side busy
	`BLP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// count never exceeds capacity
	`BLP_ASSERT_IMPL(a_count_le_cap, clk, arst_n, out_valid, entry_count <= cur_capacity)
	// empty flag agrees with count
	`BLP_ASSERT_IMPL(a_empty_flag, clk, arst_n, out_valid, is_empty == (entry_count == '0))
	// capacity stays within storage and above zero
	`BLP_ASSERT_IMPL(a_cap_range, clk, arst_n, out_valid, cur_capacity != '0 && cur_capacity <= CNT_W'(MAX_ENTRIES))

endmodule

`default_nettype wire
